>>> hdl/cross_correlation_peak_lag_defines.svh
// Assertion helpers shared by the cross-correlation peak search.
// Each macro expects clk and rst_n in scope.
`ifndef CROSS_CORRELATION_PEAK_LAG_DEFINES_SVH
`define CROSS_CORRELATION_PEAK_LAG_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCPL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCPL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ccpl_pkg.sv
package ccpl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int LAG_W    = 11;
    localparam int MEAN_W   = 32;
    localparam int LEN_W    = 12;

    // -1.0 in Q2.30
    localparam logic signed [MEAN_W-1:0] MINUS_ONE_Q30 = 32'shC000_0000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // sample_a in the low half, sample_b in the high half
    typedef struct packed {
        sample_t sample_b;
        sample_t sample_a;
    } in_data_t;

    localparam int OUT_BITS  = LAG_W + MEAN_W + LEN_W;
    localparam int OUT_PAD_W = 8 * ((OUT_BITS + 7) / 8) - OUT_BITS;

    // best_lag lowest, then best_mean, then length, zero pad on top
    typedef struct packed {
        logic [OUT_PAD_W-1:0]     pad;
        logic [LEN_W-1:0]         length;
        logic signed [MEAN_W-1:0] best_mean;
        logic [LAG_W-1:0]         best_lag;
    } out_data_t;

endpackage

>>> hdl/cross_correlation_peak_lag.sv
// Channel   Dir  Width  Contents
// s_axis    in   32+1   tdata: sample_a [15:0], sample_b [31:16]; tlast: last pair
// m_axis    out  56     tdata: best_lag [10:0], best_mean [42:11], length [54:43]
//
// Loading takes one pair per cycle; a transfer with tlast closes the load and starts
// the search, during which s_axis_tready stays low. Each lag runs (length - lag)
// multiply-accumulate steps, one product per cycle from the two sample RAMs, then
// pipeline drain, the bit-serial divider over the ACC_W-bit sum (ACC_W = 43 for
// MAX_LEN = 2048), sign fix and compare. Reset clears control only; the RAMs need
// no clearing. A result held on m_axis does not block the next load.
module cross_correlation_peak_lag #(
    parameter int MAX_LEN = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  ccpl_pkg::in_data_t  s_axis_tdata,   // [15:0] sample_a, [31:16] sample_b
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output ccpl_pkg::out_data_t m_axis_tdata    // [10:0] best_lag, [42:11] best_mean,
                                                // [54:43] length, [55] zero
);

    import ccpl_pkg::*;

    localparam int AW     = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    // |sum| <= MAX_LEN * 2^30, so PROD_W + AW bits hold it signed
    localparam int ACC_W  = PROD_W + AW;
    localparam int DCNT_W = $clog2(ACC_W + 1);

    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_LEN);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ACC_W - 1);

    // Sequencer states
    localparam logic [2:0] S_LOAD  = 3'd0;  // take sample pairs
    localparam logic [2:0] S_MAC   = 3'd1;  // issue RAM reads for one lag
    localparam logic [2:0] S_DRAIN = 3'd2;  // wait for the last product to land
    localparam logic [2:0] S_DIV   = 3'd3;  // divide |sum| by length, one bit a cycle
    localparam logic [2:0] S_SIGN  = 3'd4;  // restore the sign of the mean
    localparam logic [2:0] S_CMP   = 3'd5;  // compare with the running best
    localparam logic [2:0] S_DONE  = 3'd6;  // post the result

    logic [2:0]              state_reg,  state_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [AW-1:0]           j_reg,      j_next;
    logic [AW-1:0]           k_reg,      k_next;
    logic [AW-1:0]           lag_reg,    lag_next;
    logic                    rd_v_reg,   rd_v_next;
    logic                    rd_last_reg, rd_last_next;
    logic                    prod_v_reg, prod_v_next;
    logic                    prod_last_reg, prod_last_next;
    logic signed [PROD_W-1:0] prod_reg,  prod_next;
    logic signed [ACC_W-1:0] acc_reg,    acc_next;
    logic                    neg_reg,    neg_next;
    logic [ACC_W-1:0]        quo_reg,    quo_next;
    logic [CNT_W-1:0]        rem_reg,    rem_next;
    logic [DCNT_W-1:0]       dcnt_reg,   dcnt_next;
    logic signed [ACC_W-1:0] mean_reg,   mean_next;
    logic signed [ACC_W-1:0] best_mean_reg, best_mean_next;
    logic [AW-1:0]           best_lag_reg,  best_lag_next;
    logic                    out_valid_reg, out_valid_next;
    out_data_t               out_data_reg,  out_data_next;

    logic                    wr_en;
    logic [SAMPLE_W-1:0]     rdata_a;
    logic [SAMPLE_W-1:0]     rdata_b;
    logic [CNT_W-1:0]        len_m1;
    logic                    k_last;
    logic                    lag_last;
    logic signed [ACC_W-1:0] acc_sum;
    logic [CNT_W:0]          rem_sh;
    logic [CNT_W:0]          rem_sub;
    logic                    div_ge;

    // Sample stores: written while loading, read during the search
    assign wr_en = s_axis_tvalid && s_axis_tready && (count_reg < MAX_CNT);

    ccpl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LEN)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_axis_tdata.sample_a),
        .raddr (j_reg),
        .rdata (rdata_a)
    );

    ccpl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LEN)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_axis_tdata.sample_b),
        .raddr (k_reg),
        .rdata (rdata_b)
    );

    // During the search count_reg holds the length, always at least one
    assign len_m1   = count_reg - CNT_W'(1);
    assign k_last   = (CNT_W'(k_reg) == len_m1);
    assign lag_last = (CNT_W'(lag_reg) == len_m1);
    assign acc_sum  = acc_reg + ACC_W'(prod_reg);

    // One restoring-division step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, quo_reg[ACC_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, count_reg});
    assign rem_sub = rem_sh - {1'b0, count_reg};

    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        lag_next       = lag_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        mean_next      = mean_reg;
        best_mean_next = best_mean_reg;
        best_lag_next  = best_lag_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Read, multiply and accumulate stages follow the issue state
        rd_v_next      = (state_reg == S_MAC);
        rd_last_next   = k_last;
        prod_v_next    = rd_v_reg;
        prod_last_next = rd_last_reg;
        prod_next      = PROD_W'($signed(rdata_a) * $signed(rdata_b));
        if (prod_v_reg)
        begin
            acc_next = acc_sum;
        end

        // Drop the posted result once it is taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    // Pairs beyond the store depth are dropped
                    if (count_reg < MAX_CNT)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        state_next     = S_MAC;
                        j_next         = '0;
                        k_next         = '0;
                        lag_next       = '0;
                        acc_next       = '0;
                        best_mean_next = ACC_W'(MINUS_ONE_Q30);
                        best_lag_next  = '0;
                    end
                end
            end
            S_MAC:
            begin
                if (k_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                    k_next = k_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (prod_v_reg && prod_last_reg)
                begin
                    neg_next   = acc_sum[ACC_W-1];
                    quo_next   = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                quo_next  = {quo_reg[ACC_W-2:0], div_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DIV_LAST)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                // Truncation toward zero: negate the magnitude quotient
                mean_next  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (mean_reg > best_mean_reg)
                begin
                    best_mean_next = mean_reg;
                    best_lag_next  = lag_reg;
                end
                if (lag_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lag_next   = lag_reg + AW'(1);
                    j_next     = '0;
                    k_next     = lag_reg + AW'(1);
                    acc_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.pad       = '0;
                    out_data_next.length    = LEN_W'(count_reg);
                    out_data_next.best_mean = MEAN_W'(best_mean_reg);
                    out_data_next.best_lag  = LAG_W'(best_lag_reg);
                    count_next              = '0;
                    state_next              = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_v_reg      <= rd_v_next;
            rd_last_reg   <= rd_last_next;
            prod_v_reg    <= prod_v_next;
            prod_last_reg <= prod_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        k_reg         <= k_next;
        lag_reg       <= lag_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        neg_reg       <= neg_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dcnt_reg      <= dcnt_next;
        mean_reg      <= mean_next;
        best_mean_reg <= best_mean_next;
        best_lag_reg  <= best_lag_next;
        out_data_reg  <= out_data_next;
    end

`include "cross_correlation_peak_lag_defines.svh"

    // Read addresses of the two stores stay lag_reg apart
    `CCPL_ASSERT_NOW(a_lag_offset, state_reg == S_MAC, k_reg == AW'(j_reg + lag_reg), "lag skew")
    // The divider remainder stays below the length
    `CCPL_ASSERT_NOW(a_rem_bound, state_reg == S_DIV, rem_reg < count_reg, "remainder too large")
    // The last product of a lag hands over to the divider
    `CCPL_ASSERT_NEXT(a_div_start, prod_v_reg && prod_last_reg, state_reg == S_DIV, "divider late")
    // The MAC pipeline is empty whenever samples are loaded
    `CCPL_ASSERT_NOW(a_pipe_empty, state_reg == S_LOAD, !rd_v_reg && !prod_v_reg, "MAC busy in load")

endmodule

>>> hdl/ccpl_ram.sv
module ccpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
